@@ rtl/signed_decimal_formatter_top_assert.svh @@
// ----------------------------------------------------------------------------
// Signed decimal formatter assertion macros
// Shared property forms for the formatter modules; clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SIGNED_DECIMAL_FORMATTER_TOP_ASSERT_SVH
`define SIGNED_DECIMAL_FORMATTER_TOP_ASSERT_SVH

// same-cycle implication
`define SDF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sdf_pkg.sv @@
// ----------------------------------------------------------------------------
// Signed decimal formatter package
// Widths, ASCII codes, length modes, state types and unit interface structs.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int VALUE_W = 64;
    localparam int DIGIT_N = 20;
    localparam int DIGIT_W = 4;
    localparam int BCD_W   = DIGIT_N * DIGIT_W;
    localparam int CNT_W   = 5;
    localparam int POS_W   = 7;
    localparam int PREC_W  = 6;
    localparam int CHAR_W  = 7;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

    typedef logic [1:0] len_mode_t;

    localparam len_mode_t MODE_INT32 = 2'd0;
    localparam len_mode_t MODE_SHORT = 2'd1;
    localparam len_mode_t MODE_CHAR  = 2'd2;
    localparam len_mode_t MODE_LONG  = 2'd3;

    typedef enum logic [1:0] {
        DG_IDLE,
        DG_CONV,
        DG_NORM
    } dig_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_BOUND,
        ST_EMIT
    } fmt_state_t;

    typedef struct packed {
        logic start;
        logic shift;
    } dig_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [CNT_W-1:0]   count;
        logic [DIGIT_W-1:0] top_digit;
    } dig_status_t;

endpackage

@@ rtl/sdf_digit_unit.sv @@
// ----------------------------------------------------------------------------
// Signed decimal formatter digit unit
// Bit-serial binary to BCD conversion, leading-zero strip, digit shift-out.
// ----------------------------------------------------------------------------
`include "signed_decimal_formatter_top_assert.svh"

module sdf_digit_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sdf_pkg::dig_ctrl_t             ctrl,
    input  logic [sdf_pkg::VALUE_W-1:0]    mag,
    output sdf_pkg::dig_status_t           status
);
    import sdf_pkg::*;

    localparam int BIT_CNT_W = $clog2(VALUE_W);

    dig_state_t             state_reg, state_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [VALUE_W-1:0]     mag_reg;
    logic [BCD_W-1:0]       bcd_adj;
    logic [DIGIT_W-1:0]     top_digit;
    logic                   strip;
    logic                   done;

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign strip     = (top_digit == '0) && (count_reg > CNT_W'(1));

    always_comb
    begin
        logic [DIGIT_W-1:0] d;
        bcd_adj = bcd_reg;
        for (int i = 0; i < DIGIT_N; i++)
        begin
            d = bcd_reg[i*DIGIT_W +: DIGIT_W];
            bcd_adj[i*DIGIT_W +: DIGIT_W] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        case (state_reg)
            DG_IDLE:
            begin
                if (ctrl.start)
                    state_next = DG_CONV;
            end
            DG_CONV:
            begin
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                    state_next = DG_NORM;
            end
            DG_NORM:
            begin
                if (!strip)
                begin
                    done       = 1'b1;
                    state_next = DG_IDLE;
                end
            end
            default:
            begin
                state_next = DG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= DG_IDLE;
            bit_cnt_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DG_IDLE && ctrl.start)
                bit_cnt_reg <= '0;
            else if (state_reg == DG_CONV)
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            if (state_reg == DG_CONV)
                count_reg <= CNT_W'(DIGIT_N);
            else if (state_reg == DG_NORM && strip)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            DG_IDLE:
            begin
                if (ctrl.start)
                begin
                    mag_reg <= mag;
                    bcd_reg <= '0;
                end
                else if (ctrl.shift)
                begin
                    bcd_reg <= {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                end
            end
            DG_CONV:
            begin
                bcd_reg <= {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_reg <= {mag_reg[VALUE_W-2:0], 1'b0};
            end
            DG_NORM:
            begin
                if (strip)
                    bcd_reg <= {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            end
            default:
            begin
                bcd_reg <= bcd_reg;
            end
        endcase
    end

    assign status.done      = done;
    assign status.count     = count_reg;
    assign status.top_digit = top_digit;

    `SDF_ASSERT_IMPL(a_done_count, done,
        (count_reg >= CNT_W'(1)) && (count_reg <= CNT_W'(DIGIT_N)),
        "digit count out of range at end of conversion")
    `SDF_ASSERT_IMPL(a_no_leading_zero, done && (count_reg > CNT_W'(1)),
        top_digit != '0, "leading zero digit left after strip")
    `SDF_ASSERT_IMPL(a_conv_decimal, state_reg == DG_CONV,
        top_digit <= 4'd9, "non-decimal digit during conversion")

endmodule

@@ rtl/signed_decimal_formatter_top.sv @@
// Sequence: the 64-bit magnitude goes through a bit-serial BCD shift, leading zeros
// are stripped down to N digits (1..20), the field is sized and bounded, and the
// characters stream out, one per cycle while char_ready stays high. A new item is
// taken only in idle, after the last character of the previous one is emitted.
// Reset: asynchronous, active low; clears the sequencers and output valid.
// ----------------------------------------------------------------------------
// Signed decimal formatter top level
// Narrows a signed integer by length mode and streams it as padded ASCII.
// ----------------------------------------------------------------------------
`include "signed_decimal_formatter_top_assert.svh"

module signed_decimal_formatter_top #(
    parameter int MAX_FIELD = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  logic signed [sdf_pkg::VALUE_W-1:0] value,
    input  sdf_pkg::len_mode_t               mode,
    input  logic [sdf_pkg::POS_W-1:0]        field_width,
    input  logic [sdf_pkg::PREC_W-1:0]       precision,
    input  logic                             flag_left,
    input  logic                             flag_zero,
    input  logic                             flag_plus,
    input  logic                             flag_space,
    output logic                             char_valid,
    input  logic                             char_ready,
    output logic [sdf_pkg::CHAR_W-1:0]       out_char,
    output logic                             last_char
);
    import sdf_pkg::*;

    localparam logic [POS_W-1:0] MAX_W    = POS_W'(MAX_FIELD);
    localparam logic [POS_W-1:0] PREC_CAP = MAX_W - 1'b1;

    fmt_state_t          state_reg, state_next;
    dig_ctrl_t           ctrl;
    dig_status_t         status;

    logic [VALUE_W-1:0]  narrowed;
    logic [VALUE_W-1:0]  mag;
    logic                accept;
    logic                emit_fire;
    logic                in_digits;
    logic [CHAR_W-1:0]   char_sel;

    logic [POS_W-1:0]    width_reg;
    logic [PREC_W-1:0]   prec_reg;
    logic                left_reg;
    logic                zp_reg;
    logic                has_sign_reg;
    logic [CHAR_W-1:0]   sign_char_reg;
    logic [PREC_W-1:0]   pz_reg;
    logic [POS_W-1:0]    body_reg;
    logic [POS_W-1:0]    b1_reg, b2_reg, b4_reg, b5_reg;
    logic [POS_W-1:0]    last_pos_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                char_valid_reg;
    logic [CHAR_W-1:0]   out_char_reg;
    logic                last_reg;

    logic [PREC_W-1:0]   nd;
    logic [POS_W-1:0]    total;
    logic [POS_W-1:0]    pad;
    logic [POS_W-1:0]    lead;
    logic [POS_W-1:0]    b2_val;
    logic [POS_W-1:0]    b4_val;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        case (mode)
            MODE_INT32: narrowed = {{32{value[31]}}, value[31:0]};
            MODE_SHORT: narrowed = {{48{value[15]}}, value[15:0]};
            MODE_CHAR:  narrowed = {{56{value[7]}}, value[7:0]};
            default:    narrowed = value;
        endcase
        mag = narrowed[VALUE_W-1] ? '0 - narrowed : narrowed;
    end

    assign nd     = (prec_reg > PREC_W'(status.count)) ? prec_reg : PREC_W'(status.count);
    assign total  = (width_reg > body_reg) ? width_reg : body_reg;
    assign pad    = total - body_reg;
    assign lead   = (!left_reg && !zp_reg) ? pad : '0;
    assign b2_val = lead + POS_W'(has_sign_reg);
    assign b4_val = b2_val + (zp_reg ? pad : '0) + POS_W'(pz_reg);

    assign in_digits = (pos_reg >= b4_reg) && (pos_reg < b5_reg);
    assign emit_fire = (state_reg == ST_EMIT) && (!char_valid_reg || char_ready);

    always_comb
    begin
        if (pos_reg < b1_reg)
            char_sel = CH_SPACE;
        else if (pos_reg < b2_reg)
            char_sel = sign_char_reg;
        else if (pos_reg < b4_reg)
            char_sel = CH_ZERO;
        else if (pos_reg < b5_reg)
            char_sel = CH_ZERO + CHAR_W'(status.top_digit);
        else
            char_sel = CH_SPACE;
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl.start = 1'b0;
        ctrl.shift = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.start = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (status.done)
                    state_next = ST_SIZE;
            end
            ST_SIZE:
            begin
                state_next = ST_BOUND;
            end
            ST_BOUND:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                ctrl.shift = emit_fire && in_digits;
                if (emit_fire && pos_reg == last_pos_reg)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    sdf_digit_unit u_digit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .mag    (mag),
        .status (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            char_valid_reg <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_fire)
                char_valid_reg <= 1'b1;
            else if (char_ready)
                char_valid_reg <= 1'b0;
            if (state_reg == ST_BOUND)
                pos_reg <= '0;
            else if (emit_fire)
                pos_reg <= pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            width_reg    <= (field_width > MAX_W) ? MAX_W : field_width;
            prec_reg     <= ({1'b0, precision} > PREC_CAP) ? PREC_CAP[PREC_W-1:0]
                                                             : precision;
            left_reg     <= flag_left;
            zp_reg       <= flag_zero && (precision == '0) && !flag_left;
            has_sign_reg <= narrowed[VALUE_W-1] || flag_plus || flag_space;
            if (narrowed[VALUE_W-1])
                sign_char_reg <= CH_MINUS;
            else if (flag_plus)
                sign_char_reg <= CH_PLUS;
            else
                sign_char_reg <= CH_SPACE;
        end
        if (state_reg == ST_SIZE)
        begin
            pz_reg   <= nd - PREC_W'(status.count);
            body_reg <= POS_W'(nd) + POS_W'(has_sign_reg);
        end
        if (state_reg == ST_BOUND)
        begin
            b1_reg       <= lead;
            b2_reg       <= b2_val;
            b4_reg       <= b4_val;
            b5_reg       <= b4_val + POS_W'(status.count);
            last_pos_reg <= total - 1'b1;
        end
        if (emit_fire)
        begin
            out_char_reg <= char_sel;
            last_reg     <= (pos_reg == last_pos_reg);
        end
    end

    assign char_valid = char_valid_reg;
    assign out_char   = out_char_reg;
    assign last_char  = last_reg;

    `SDF_ASSERT_IMPL(a_pos_in_range, state_reg == ST_EMIT,
        pos_reg <= last_pos_reg, "emit position past final character")
    `SDF_ASSERT_IMPL(a_total_fits, state_reg == ST_EMIT,
        (last_pos_reg < MAX_W) || (last_pos_reg <= POS_W'(DIGIT_N)),
        "conversion longer than maximum field")
    `SDF_ASSERT_IMPL(a_digit_decimal, emit_fire && in_digits,
        status.top_digit <= 4'd9, "non-decimal digit emitted")
    `SDF_ASSERT_NEXT(a_last_to_idle, emit_fire && (pos_reg == last_pos_reg),
        (state_reg == ST_IDLE) && char_valid_reg && last_reg,
        "final character not marked or sequencer not idle")

endmodule

@@ sim/tb_signed_decimal_formatter_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Signed decimal formatter testbench
// Sends directed and random conversion specs across all length modes, flags,
// widths and precisions, predicts each character string in the bench, and
// checks every character and end marker in order under random stalls on
// both sides.
// ----------------------------------------------------------------------------
module tb_signed_decimal_formatter_top;

    import sdf_pkg::*;

    localparam int MAX_FIELD  = 64;
    localparam int N_RANDOM   = 126;
    localparam int DRAIN_AT   = 70;
    localparam int HOLD_AT    = 40;
    localparam int LONG_HOLD  = 500;
    localparam int CALM_LEFT  = 25;
    localparam int TAIL_WAIT  = 150;
    localparam int PRINT_CAP  = 100;

    localparam logic [3:0] F_NONE  = 4'b0000;
    localparam logic [3:0] F_LEFT  = 4'b1000;
    localparam logic [3:0] F_ZERO  = 4'b0100;
    localparam logic [3:0] F_PLUS  = 4'b0010;
    localparam logic [3:0] F_SPACE = 4'b0001;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        len_mode_t                 mode;
        logic [POS_W-1:0]          field_width;
        logic [PREC_W-1:0]         precision;
        logic                      flag_left;
        logic                      flag_zero;
        logic                      flag_plus;
        logic                      flag_space;
        bit                        drain_first;
    } conv_spec_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } exp_char_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      item_valid = 1'b0;
    logic                      item_ready;
    logic signed [VALUE_W-1:0] value = '0;
    len_mode_t                 mode = MODE_INT32;
    logic [POS_W-1:0]          field_width = '0;
    logic [PREC_W-1:0]         precision = '0;
    logic                      flag_left = 1'b0;
    logic                      flag_zero = 1'b0;
    logic                      flag_plus = 1'b0;
    logic                      flag_space = 1'b0;
    logic                      char_valid;
    logic                      char_ready = 1'b0;
    logic [CHAR_W-1:0]         out_char;
    logic                      last_char;

    conv_spec_t pending_specs[$];
    exp_char_t  expected_chars[$];
    conv_spec_t offered_spec;

    int  items_accepted = 0;
    int  chars_checked  = 0;
    int  mismatch_count = 0;
    int  n_directed     = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    bit  calm           = 1'b0;

    signed_decimal_formatter_top #(
        .MAX_FIELD (MAX_FIELD)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .value       (value),
        .mode        (mode),
        .field_width (field_width),
        .precision   (precision),
        .flag_left   (flag_left),
        .flag_zero   (flag_zero),
        .flag_plus   (flag_plus),
        .flag_space  (flag_space),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .out_char    (out_char),
        .last_char   (last_char)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic void format_decimal(input conv_spec_t s);
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic [DIGIT_W-1:0] digs [DIGIT_N];
        logic [CHAR_W-1:0]  sign_ch;
        logic [CHAR_W-1:0]  chars[$];
        bit                 has_sign;
        bit                 zero_pad;
        int                 n, nd, body, total, pad_n, wd, pr, i;
        exp_char_t          e;
        case (s.mode)
            MODE_INT32: v = {{32{s.value[31]}}, s.value[31:0]};
            MODE_SHORT: v = {{48{s.value[15]}}, s.value[15:0]};
            MODE_CHAR:  v = {{56{s.value[7]}}, s.value[7:0]};
            MODE_LONG:  v = s.value;
            default:    v = s.value;
        endcase
        neg = v[VALUE_W-1];
        mag = neg ? (64'd0 - v) : v;
        n = 0;
        do
        begin
            digs[n] = DIGIT_W'(mag % 10);
            mag = mag / 10;
            n++;
        end
        while (mag != 0 && n < DIGIT_N);
        has_sign = 1'b1;
        if (neg)
            sign_ch = CH_MINUS;
        else if (s.flag_plus)
            sign_ch = CH_PLUS;
        else if (s.flag_space)
            sign_ch = CH_SPACE;
        else
        begin
            sign_ch = CH_SPACE;
            has_sign = 1'b0;
        end
        wd = (int'(s.field_width) > MAX_FIELD) ? MAX_FIELD : int'(s.field_width);
        zero_pad = s.flag_zero && s.precision == 0 && !s.flag_left;
        pr = (int'(s.precision) > MAX_FIELD - 1) ? MAX_FIELD - 1 : int'(s.precision);
        nd = (pr > n) ? pr : n;
        body = nd + int'(has_sign);
        total = (wd > body) ? wd : body;
        pad_n = total - body;
        if (!s.flag_left && !zero_pad)
            for (i = 0; i < pad_n; i++)
                chars.push_back(CH_SPACE);
        if (has_sign)
            chars.push_back(sign_ch);
        if (zero_pad)
            for (i = 0; i < pad_n; i++)
                chars.push_back(CH_ZERO);
        for (i = n; i < nd; i++)
            chars.push_back(CH_ZERO);
        for (i = n; i > 0; i--)
            chars.push_back(CH_ZERO + CHAR_W'(digs[i-1]));
        if (s.flag_left)
            for (i = 0; i < pad_n; i++)
                chars.push_back(CH_SPACE);
        for (i = 0; i < chars.size(); i++)
        begin
            e.ch = chars[i];
            e.last = (i == chars.size() - 1);
            expected_chars.push_back(e);
        end
    endfunction

    function automatic conv_spec_t spec(input logic signed [VALUE_W-1:0] v, input len_mode_t m,
                                        input int w, input int p, input logic [3:0] f);
        conv_spec_t s;
        s.value       = v;
        s.mode        = m;
        s.field_width = POS_W'(w);
        s.precision   = PREC_W'(p);
        s.flag_left   = f[3];
        s.flag_zero   = f[2];
        s.flag_plus   = f[1];
        s.flag_space  = f[0];
        s.drain_first = 1'b0;
        return s;
    endfunction

    function automatic conv_spec_t random_spec();
        conv_spec_t         s;
        logic [VALUE_W-1:0] raw;
        int                 r;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: ;
            1:
            begin
                raw = raw >> $urandom_range(1, 63);
                if ($urandom_range(0, 1) == 1)
                    raw = 64'd0 - raw;
            end
            2: raw = 64'($urandom_range(0, 2000)) - 64'd1000;
            default:
                case ($urandom_range(0, 5))
                    0: raw = 64'h8000_0000_0000_0000;
                    1: raw = 64'h7FFF_FFFF_FFFF_FFFF;
                    2: raw = {raw[63:32], 32'h8000_0000};
                    3: raw = {raw[63:16], 16'h7FFF};
                    4: raw = {raw[63:8], 8'h80};
                    default: raw = '0;
                endcase
        endcase
        s.value = raw;
        s.mode  = len_mode_t'($urandom_range(0, 3));
        r = $urandom_range(0, 9);
        s.field_width = (r == 0) ? POS_W'($urandom_range(25, 127))
                                 : POS_W'($urandom_range(0, 24));
        r = $urandom_range(0, 9);
        if (r < 5)
            s.precision = '0;
        else if (r < 9)
            s.precision = PREC_W'($urandom_range(1, 20));
        else
            s.precision = PREC_W'($urandom_range(21, 63));
        s.flag_left   = 1'($urandom_range(0, 1));
        s.flag_zero   = 1'($urandom_range(0, 1));
        s.flag_plus   = 1'($urandom_range(0, 1));
        s.flag_space  = 1'($urandom_range(0, 1));
        s.drain_first = 1'b0;
        return s;
    endfunction

    always @(posedge clk)
    begin : drive_proc
        conv_spec_t nxt;
        logic       offer;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            offer = item_valid;
            if (item_valid && item_ready)
            begin
                format_decimal(offered_spec);
                items_accepted <= items_accepted + 1;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                else if (pending_specs.size() != 0 &&
                         !(pending_specs[0].drain_first && expected_chars.size() != 0))
                begin
                    if (!calm && $urandom_range(0, 3) == 0)
                        gap_left <= $urandom_range(0, 13);
                    else
                    begin
                        nxt = pending_specs.pop_front();
                        offered_spec <= nxt;
                        value        <= nxt.value;
                        mode         <= nxt.mode;
                        field_width  <= nxt.field_width;
                        precision    <= nxt.precision;
                        flag_left    <= nxt.flag_left;
                        flag_zero    <= nxt.flag_zero;
                        flag_plus    <= nxt.flag_plus;
                        flag_space   <= nxt.flag_space;
                        offer = 1'b1;
                    end
                end
            end
            item_valid <= offer;
            calm <= (pending_specs.size() < CALM_LEFT);
        end
    end

    always @(posedge clk)
    begin : sink_proc
        exp_char_t want;
        logic      rdy;
        if (!rst_n)
        begin
            char_ready <= 1'b0;
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                chars_checked++;
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("unexpected character 0x%02h", out_char));
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_char !== want.ch)
                        report_mismatch($sformatf("out_char 0x%02h, predicted 0x%02h",
                                                  out_char, want.ch));
                    if (last_char !== want.last)
                        report_mismatch($sformatf("last_char %b, predicted %b",
                                                  last_char, want.last));
                end
            end
            rdy = 1'b1;
            if (!hold_done && items_accepted >= HOLD_AT)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                rdy = 1'b0;
            end
            char_ready <= rdy;
        end
    end

    initial
    begin : stimulus
        conv_spec_t s;
        int         i;
        pending_specs.push_back(spec(64'sd0, MODE_LONG, 0, 0, F_NONE));
        pending_specs.push_back(spec(64'sd0, MODE_INT32, 0, 0, F_PLUS));
        pending_specs.push_back(spec(64'sh8000_0000_0000_0000, MODE_LONG, 0, 0, F_NONE));
        pending_specs.push_back(spec(64'sh7FFF_FFFF_FFFF_FFFF, MODE_LONG, 0, 0, F_PLUS));
        pending_specs.push_back(spec(64'sh1234_5678_8000_0000, MODE_INT32, 0, 0, F_NONE));
        pending_specs.push_back(spec(64'shFFFF_0000_7FFF_FFFF, MODE_INT32, 12, 0, F_SPACE));
        pending_specs.push_back(spec(64'shABCD_EF01_2345_8000, MODE_SHORT, 0, 0, F_NONE));
        pending_specs.push_back(spec(64'sh0000_0000_FFFF_7FFF, MODE_SHORT, 8, 0, F_LEFT | F_PLUS));
        pending_specs.push_back(spec(64'sh5A5A_5A5A_5A5A_5A80, MODE_CHAR, 0, 0, F_NONE));
        pending_specs.push_back(spec(64'shFFFF_FFFF_FFFF_FF7F, MODE_CHAR, 10, 0, F_LEFT));
        pending_specs.push_back(spec(-64'sd1, MODE_CHAR, 5, 0, F_ZERO));
        pending_specs.push_back(spec(64'sd37, MODE_INT32, 8, 4, F_ZERO));
        pending_specs.push_back(spec(-64'sd37, MODE_INT32, 8, 0, F_ZERO | F_LEFT));
        pending_specs.push_back(spec(64'sd42, MODE_LONG, 127, 0, F_NONE));
        pending_specs.push_back(spec(-64'sd9, MODE_SHORT, 64, 63, F_NONE));
        pending_specs.push_back(spec(64'sd1, MODE_LONG, 0, 63, F_PLUS));
        pending_specs.push_back(spec(64'sd123, MODE_INT32, 100, 0, F_ZERO | F_SPACE));
        pending_specs.push_back(spec(64'sd5, MODE_INT32, 3, 0, F_PLUS | F_SPACE));
        pending_specs.push_back(spec(64'sd5, MODE_INT32, 3, 0, F_SPACE));
        pending_specs.push_back(spec(-64'sd123456789, MODE_LONG, 2, 0, F_NONE));
        pending_specs.push_back(spec(64'sd9999, MODE_SHORT, 0, 4, F_NONE));
        pending_specs.push_back(spec(-64'sd5, MODE_LONG, 6, 0, F_ZERO));
        pending_specs.push_back(spec(64'sd0, MODE_CHAR, 0, 3, F_SPACE));
        pending_specs.push_back(spec(64'sd7, MODE_LONG, 5, 0,
                                     F_ZERO | F_LEFT | F_PLUS | F_SPACE));
        n_directed = pending_specs.size();
        for (i = 0; i < N_RANDOM; i++)
        begin
            s = random_spec();
            s.drain_first = (i == DRAIN_AT);
            pending_specs.push_back(s);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_specs.size() != 0 || item_valid || expected_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("ran %0d conversions (%0d directed) over all length modes and flag mixes,",
                 items_accepted, n_directed);
        $display("%0d characters checked, including a long output hold and a full drain pause",
                 chars_checked);
        if (mismatch_count == 0)
            $display("[signed_decimal_formatter_top] OK");
        else
            $display("[signed_decimal_formatter_top] ERROR");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("timeout with %0d characters still pending", expected_chars.size());
        $display("[signed_decimal_formatter_top] ERROR");
        $finish;
    end

endmodule
